// ===== rtl/lcfd_pkg.sv =====
// Package for the length/CRC-32C frame decoder: field codes, result struct
// and the byte-wide CRC-32C update function. No dependencies.
`default_nettype none

package lcfd_pkg;

    // Header layout: four length bytes then four CRC bytes, little endian
    localparam int HEADER_BYTES = 8;
    localparam int LEN_BYTES    = 4;
    localparam int HDR_POS_W    = $clog2(HEADER_BYTES);
    localparam logic [HDR_POS_W-1:0] LAST_HDR_POS = HDR_POS_W'(HEADER_BYTES - 1);

    // CRC-32C, reflected form
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Reset value of the max payload register
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

    // Register index on the config port
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    // Input function codes
    localparam logic FUNC_DATA    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
    localparam logic [1:0] STATUS_OVERSIZE = 2'd2;
    localparam logic [1:0] STATUS_FAILED   = 2'd3;

    // One result item plus its valid flag
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic [1:0]  status;
        logic [31:0] frames_done;
    } result_t;

    // One byte of CRC-32C, LSB first
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lcfd_cfg.sv =====
// APB-style configuration register block for the frame decoder.
// Holds max_payload_bytes; depends on lcfd_pkg.
`default_nettype none

module lcfd_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [31:0]      max_payload
);

    logic [31:0] max_payload_reg;
    logic        wr_en;

    // Write in the access phase of a transaction
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == lcfd_pkg::REG_MAX_PAYLOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= lcfd_pkg::MAX_PAYLOAD_RESET;
        else if (wr_en)
            max_payload_reg <= pwdata;
    end

    // Read decode
    always_comb
    begin
        unique case (paddr[2])
            lcfd_pkg::REG_MAX_PAYLOAD: prdata = max_payload_reg;
            default:                   prdata = 32'd0;
        endcase
    end

    assign max_payload = max_payload_reg;

endmodule

`default_nettype wire

// ===== rtl/lcfd_core.sv =====
// Frame decode state and next-state logic: header capture, length check,
// CRC-32C update and verdict. Depends on lcfd_pkg.
`default_nettype none

module lcfd_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        func,
    input  wire logic [7:0]  data_byte,
    input  wire logic [31:0] max_payload,
    output lcfd_pkg::result_t res
);

    logic [lcfd_pkg::HDR_POS_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic        in_payload_reg, in_payload_next;
    logic [31:0] decl_len_reg, decl_len_next;
    logic [31:0] exp_crc_reg, exp_crc_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] crc_reg, crc_next;
    logic        failed_reg, failed_next;
    logic [31:0] good_cnt_reg, good_cnt_next;

    logic [31:0] crc_upd;
    logic [31:0] rem_dec;
    logic [31:0] crc_full;

    assign crc_upd  = lcfd_pkg::crc32c_byte(crc_reg, data_byte);
    assign rem_dec  = remaining_reg - 32'd1;
    // Complete header CRC once its top byte arrives
    assign crc_full = {data_byte, exp_crc_reg[23:0]};

    // Next state and result for the item at the input
    always_comb
    begin
        hdr_pos_next    = hdr_pos_reg;
        in_payload_next = in_payload_reg;
        decl_len_next   = decl_len_reg;
        exp_crc_next    = exp_crc_reg;
        remaining_next  = remaining_reg;
        crc_next        = crc_reg;
        failed_next     = failed_reg;
        good_cnt_next   = good_cnt_reg;

        res              = '0;
        res.kind         = lcfd_pkg::KIND_PAYLOAD;
        res.status       = lcfd_pkg::STATUS_OK;

        if (func == lcfd_pkg::FUNC_RESTART)
        begin
            hdr_pos_next    = '0;
            in_payload_next = 1'b0;
            decl_len_next   = '0;
            exp_crc_next    = '0;
            remaining_next  = '0;
            crc_next        = lcfd_pkg::CRC_INIT;
            failed_next     = 1'b0;
            good_cnt_next   = '0;
        end
        else if (failed_reg)
        begin
            res.valid  = 1'b1;
            res.kind   = lcfd_pkg::KIND_ERROR;
            res.status = lcfd_pkg::STATUS_FAILED;
        end
        else if (!in_payload_reg)
        begin
            // Header byte: fill its lane
            if (hdr_pos_reg[lcfd_pkg::HDR_POS_W-1] == 1'b0)
                decl_len_next[{hdr_pos_reg[1:0], 3'b000} +: 8] = data_byte;
            else
                exp_crc_next[{hdr_pos_reg[1:0], 3'b000} +: 8] = data_byte;

            if (hdr_pos_reg != lcfd_pkg::LAST_HDR_POS)
                hdr_pos_next = hdr_pos_reg + 1'b1;
            else
            begin
                hdr_pos_next = '0;
                if (decl_len_reg > max_payload)
                begin
                    failed_next = 1'b1;
                    res.valid   = 1'b1;
                    res.kind    = lcfd_pkg::KIND_ERROR;
                    res.status  = lcfd_pkg::STATUS_OVERSIZE;
                end
                else if (decl_len_reg == 32'd0)
                begin
                    // Empty payload: CRC of nothing is zero
                    res.valid = 1'b1;
                    res.kind  = lcfd_pkg::KIND_EMPTY;
                    if (crc_full != 32'd0)
                    begin
                        failed_next = 1'b1;
                        res.status  = lcfd_pkg::STATUS_CRC_BAD;
                    end
                    else
                        good_cnt_next = good_cnt_reg + 32'd1;
                    decl_len_next = '0;
                    exp_crc_next  = '0;
                end
                else
                begin
                    in_payload_next = 1'b1;
                    remaining_next  = decl_len_reg;
                    crc_next        = lcfd_pkg::CRC_INIT;
                end
            end
        end
        else
        begin
            // Payload byte, passed straight through
            crc_next         = crc_upd;
            remaining_next   = rem_dec;
            res.valid        = 1'b1;
            res.kind         = lcfd_pkg::KIND_PAYLOAD;
            res.payload_byte = data_byte;
            if (rem_dec == 32'd0)
            begin
                res.frame_last = 1'b1;
                if ((crc_upd ^ lcfd_pkg::CRC_INIT) != exp_crc_reg)
                begin
                    failed_next = 1'b1;
                    res.status  = lcfd_pkg::STATUS_CRC_BAD;
                end
                else
                    good_cnt_next = good_cnt_reg + 32'd1;
                in_payload_next = 1'b0;
                decl_len_next   = '0;
                exp_crc_next    = '0;
                crc_next        = lcfd_pkg::CRC_INIT;
            end
        end

        res.frames_done = good_cnt_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg    <= '0;
            in_payload_reg <= 1'b0;
            decl_len_reg   <= '0;
            exp_crc_reg    <= '0;
            remaining_reg  <= '0;
            crc_reg        <= lcfd_pkg::CRC_INIT;
            failed_reg     <= 1'b0;
            good_cnt_reg   <= '0;
        end
        else if (accept)
        begin
            hdr_pos_reg    <= hdr_pos_next;
            in_payload_reg <= in_payload_next;
            decl_len_reg   <= decl_len_next;
            exp_crc_reg    <= exp_crc_next;
            remaining_reg  <= remaining_next;
            crc_reg        <= crc_next;
            failed_reg     <= failed_next;
            good_cnt_reg   <= good_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lcfd_out_stage.sv =====
// Result register of the frame decoder: holds one result until taken,
// and tells the input side when a new transaction may enter. Uses lcfd_pkg.
`default_nettype none

module lcfd_out_stage (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  lcfd_pkg::result_t res,
    input  wire logic        out_ready,
    output logic             space,
    output logic             out_valid,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic             frame_last,
    output logic [1:0]       status,
    output logic [31:0]      frames_done
);

    logic              valid_reg;
    lcfd_pkg::result_t data_reg;

    // Room for a new result when empty or being drained this cycle
    assign space = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= res.valid;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load && res.valid)
            data_reg <= res;
    end

    assign out_valid    = valid_reg;
    assign kind         = data_reg.kind;
    assign payload_byte = data_reg.payload_byte;
    assign frame_last   = data_reg.frame_last;
    assign status       = data_reg.status;
    assign frames_done  = data_reg.frames_done;

endmodule

`default_nettype wire

// ===== rtl/length_crc_frame_decoder.sv =====
// Top level of the length-prefixed CRC-32C frame decoder.
// Instantiates lcfd_cfg, lcfd_core and lcfd_out_stage; uses lcfd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, func, data_byte) carries one link byte
//   or a restart per transaction. Output channel (out_valid/out_ready) carries
//   at most one result per input: passed-through payload bytes (last one
//   marked with the CRC verdict), empty-frame completions and error reports.
//   Header bytes produce no result except on the eighth one.
//   Timing: a result appears in the cycle after its input is accepted.
//   Throughput: one byte per cycle unless stalled, set by the combinational
//   decode and CRC-32C byte update between the state and result registers.
//   Stall: the result register holds one result; in_ready drops while it is
//   full and out_ready is low, and rises again as it drains.
//   Reset: decode state clears, CRC seeds to all ones, max_payload_bytes
//   returns to 65536. A restart input clears decode state and the good
//   frame count but keeps the register.
//   Config: APB-style write of max_payload_bytes at address 0, while idle.
`default_nettype none

module length_crc_frame_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [7:0]  data_byte,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic             frame_last,
    output logic [1:0]       status,
    output logic [31:0]      frames_done
);

    logic [31:0]       max_payload;
    logic              accept;
    lcfd_pkg::result_t res;

    assign accept = in_valid && in_ready;

    lcfd_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_payload (max_payload)
    );

    lcfd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (func),
        .data_byte   (data_byte),
        .max_payload (max_payload),
        .res         (res)
    );

    lcfd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .res          (res),
        .out_ready    (out_ready),
        .space        (in_ready),
        .out_valid    (out_valid),
        .kind         (kind),
        .payload_byte (payload_byte),
        .frame_last   (frame_last),
        .status       (status),
        .frames_done  (frames_done)
    );

endmodule

`default_nettype wire

// ===== rtl/lcfd_checker.sv =====
// Port-level checker for the frame decoder and its bind to the top level.
// Depends on lcfd_pkg and length_crc_frame_decoder.
`default_nettype none

module lcfd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  kind,
    input wire logic [7:0]  payload_byte,
    input wire logic        frame_last,
    input wire logic [1:0]  status,
    input wire logic [31:0] frames_done
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte)
            && $stable(frame_last) && $stable(status) && $stable(frames_done))
        else $error("stalled result changed");

    // Empty output register always has room
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    // Last mark only on payload bytes
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> kind == lcfd_pkg::KIND_PAYLOAD)
        else $error("frame_last on non-payload result");

    // Mid-frame payload bytes carry no verdict
    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == lcfd_pkg::KIND_PAYLOAD && !frame_last
            |-> status == lcfd_pkg::STATUS_OK)
        else $error("status set on mid-frame byte");

    // Error reports carry an error status
    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == lcfd_pkg::KIND_ERROR
            |-> status == lcfd_pkg::STATUS_OVERSIZE || status == lcfd_pkg::STATUS_FAILED)
        else $error("error report with wrong status");

endmodule

bind length_crc_frame_decoder lcfd_checker u_lcfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .frame_last   (frame_last),
    .status       (status),
    .frames_done  (frames_done)
);

`default_nettype wire

// ===== verif/frame_decode_checker.sv =====
// Scoreboard for the length/CRC-32C frame decoder: watches the config port and
// both streams, predicts each result from the byte stream and compares fields.
// Depends on lcfd_pkg for the field codes and the register reset value.
module frame_decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        func,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  payload_byte,
    input  logic        frame_last,
    input  logic [1:0]  status,
    input  logic [31:0] frames_done,
    output int          pending_results,
    output int          mismatch_count,
    output int          checked_count,
    output int          frame_end_count,
    output int          error_report_count
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [1:0]  status;
        logic [31:0] frames;
    } decoded_t;

    // Results predicted but not yet seen on the output
    decoded_t decoded_due[$];

    // Shadow of the length limit register
    logic [31:0] limit_shadow;

    // Shadow of the decode state
    logic [3:0]  hdr_idx;
    logic        in_body;
    logic [31:0] length_field;
    logic [31:0] crc_field;
    logic [31:0] left_count;
    logic [31:0] crc_acc;
    logic        failed;
    logic [31:0] good_frames;

    int mismatches;
    int checked;
    int frame_ends;
    int error_reports;

    // Reflected CRC-32C, one byte, LSB first
    function automatic logic [31:0] crc32c_step(input logic [31:0] acc,
                                                input logic [7:0]  value);
        logic [31:0] r;
        r = acc ^ {24'd0, value};
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ lcfd_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void clear_decode();
        hdr_idx      = '0;
        in_body      = 1'b0;
        length_field = '0;
        crc_field    = '0;
        left_count   = '0;
        crc_acc      = '1;
        failed       = 1'b0;
        good_frames  = '0;
    endfunction

    // Advance the shadow state by one input transaction; returns 1 with the
    // predicted result when the transaction yields one
    function automatic bit decode_byte(input logic f, input logic [7:0] b,
                                       output decoded_t r);
        logic [3:0] next_idx;
        r = '0;
        if (f == lcfd_pkg::FUNC_RESTART)
        begin
            clear_decode();
            return 1'b0;
        end
        if (failed)
        begin
            r.kind   = lcfd_pkg::KIND_ERROR;
            r.status = lcfd_pkg::STATUS_FAILED;
            r.frames = good_frames;
            return 1'b1;
        end

        // Header: length then CRC, both little endian
        if (!in_body)
        begin
            if (hdr_idx < lcfd_pkg::LEN_BYTES)
                length_field |= 32'(b) << (8 * hdr_idx);
            else
                crc_field |= 32'(b) << (8 * (hdr_idx - lcfd_pkg::LEN_BYTES));
            next_idx = hdr_idx + 4'd1;
            if (next_idx < lcfd_pkg::HEADER_BYTES)
            begin
                hdr_idx = next_idx;
                return 1'b0;
            end
            hdr_idx = '0;
            if (length_field > limit_shadow)
            begin
                failed   = 1'b1;
                r.kind   = lcfd_pkg::KIND_ERROR;
                r.status = lcfd_pkg::STATUS_OVERSIZE;
                r.frames = good_frames;
                return 1'b1;
            end
            // Empty payload: CRC of nothing is zero
            if (length_field == 0)
            begin
                if (crc_field != 0)
                begin
                    failed   = 1'b1;
                    r.status = lcfd_pkg::STATUS_CRC_BAD;
                end
                else
                    good_frames++;
                length_field = '0;
                crc_field    = '0;
                r.kind       = lcfd_pkg::KIND_EMPTY;
                r.frames     = good_frames;
                return 1'b1;
            end
            in_body    = 1'b1;
            left_count = length_field;
            crc_acc    = '1;
            return 1'b0;
        end

        // Payload byte, passed straight through
        crc_acc = crc32c_step(crc_acc, b);
        left_count--;
        r.kind = lcfd_pkg::KIND_PAYLOAD;
        r.data = b;
        if (left_count != 0)
        begin
            r.frames = good_frames;
            return 1'b1;
        end
        r.last = 1'b1;
        if (~crc_acc != crc_field)
        begin
            failed   = 1'b1;
            r.status = lcfd_pkg::STATUS_CRC_BAD;
        end
        else
            good_frames++;
        in_body      = 1'b0;
        length_field = '0;
        crc_field    = '0;
        crc_acc      = '1;
        r.frames     = good_frames;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        decoded_t got;
        decoded_t want;
        if (!rst_n)
        begin
            limit_shadow = lcfd_pkg::MAX_PAYLOAD_RESET;
            clear_decode();
            decoded_due.delete();
        end
        else
        begin
            // Config port: track writes, check read data
            if (psel && penable && pready
                && ((paddr >> 2) == 3'(lcfd_pkg::REG_MAX_PAYLOAD)))
            begin
                if (pwrite)
                    limit_shadow = pwdata;
                else if (prdata !== limit_shadow)
                begin
                    $error("prdata: expected %0h, got %0h", limit_shadow, prdata);
                    mismatches++;
                end
            end

            // Output transaction against the oldest prediction
            if (out_valid && out_ready)
            begin
                checked++;
                if (decoded_due.size() == 0)
                begin
                    $error("result with nothing predicted: kind %0d status %0d",
                           kind, status);
                    mismatches++;
                end
                else
                begin
                    want = decoded_due.pop_front();
                    if (want.kind == lcfd_pkg::KIND_EMPTY || want.last)
                        frame_ends++;
                    if (want.kind == lcfd_pkg::KIND_ERROR)
                        error_reports++;
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        mismatches++;
                    end
                    if (payload_byte !== want.data)
                    begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.data, payload_byte);
                        mismatches++;
                    end
                    if (frame_last !== want.last)
                    begin
                        $error("frame_last: expected %0d, got %0d", want.last, frame_last);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                    if (frames_done !== want.frames)
                    begin
                        $error("frames_done: expected %0d, got %0d",
                               want.frames, frames_done);
                        mismatches++;
                    end
                end
            end

            // Input transaction: predict
            if (in_valid && in_ready)
            begin
                if (decode_byte(func, data_byte, got))
                    decoded_due.push_back(got);
            end
        end
        pending_results    <= decoded_due.size();
        mismatch_count     <= mismatches;
        checked_count      <= checked;
        frame_end_count    <= frame_ends;
        error_report_count <= error_reports;
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the frame decoder testbench: clock, reset, config writes, framed and
// broken byte streams with random idling, and the final verdict.
// Depends on lcfd_pkg, length_crc_frame_decoder and frame_decode_checker.
module testbench;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 80;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int PHASES          = 7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        func      = lcfd_pkg::FUNC_DATA;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic [1:0]  status;
    logic [31:0] frames_done;

    int pending_results;
    int mismatch_count;
    int checked_count;
    int frame_end_count;
    int error_report_count;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_requests  = 0;
    int          hold_served    = 0;
    int          hold_left      = 0;
    int          items_sent     = 0;
    int          restarts_sent  = 0;
    int          cycles         = 0;
    logic [31:0] cur_limit      = lcfd_pkg::MAX_PAYLOAD_RESET;

    length_crc_frame_decoder DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
        .payload_byte(payload_byte), .frame_last(frame_last), .status(status),
        .frames_done(frames_done)
    );

    frame_decode_checker frame_check (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
        .payload_byte(payload_byte), .frame_last(frame_last), .status(status),
        .frames_done(frames_done),
        .pending_results(pending_results), .mismatch_count(mismatch_count),
        .checked_count(checked_count), .frame_end_count(frame_end_count),
        .error_report_count(error_report_count)
    );

    always #10 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // CRC-32C over frame bodies, for building headers
    function automatic logic [31:0] body_crc_update(input logic [31:0] acc,
                                                    input logic [7:0]  value);
        logic [31:0] r;
        r = acc ^ {24'd0, value};
        for (int i = 0; i < 8; i++)
        begin
            if (r[0])
                r = (r >> 1) ^ lcfd_pkg::CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    // Length limit used in each random phase
    function automatic logic [31:0] phase_limit(input int idx);
        case (idx)
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd3;
            3:       return 32'd24;
            4:       return 32'd1;
            5:       return 32'd65536;
            default: return 32'd8;
        endcase
    endfunction

    // Mostly short payloads, now and then an empty or longer one
    function automatic logic [31:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return 32'd0;
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 24);
        return $urandom_range(25, 64);
    endfunction

    // One input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic f, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (f == lcfd_pkg::FUNC_RESTART)
            restarts_sent++;
    endtask

    task automatic send_restart();
        send_item(lcfd_pkg::FUNC_RESTART, 8'($urandom_range(255)));
    endtask

    task automatic send_header(input logic [31:0] len, input logic [31:0] crc);
        for (int k = 0; k < 4; k++)
            send_item(lcfd_pkg::FUNC_DATA, len[8*k +: 8]);
        for (int k = 0; k < 4; k++)
            send_item(lcfd_pkg::FUNC_DATA, crc[8*k +: 8]);
    endtask

    // Header plus body_len random bytes; the CRC covers the bytes sent
    task automatic send_packet(input logic [31:0] len, input int body_len, input bit bad_crc);
        logic [7:0]  body[$];
        logic [31:0] acc;
        acc = '1;
        for (int i = 0; i < body_len; i++)
        begin
            body.push_back(8'($urandom_range(255)));
            acc = body_crc_update(acc, body[i]);
        end
        acc = ~acc;
        if (bad_crc)
            acc ^= 32'd1 << $urandom_range(31);
        send_header(len, acc);
        foreach (body[i])
            send_item(lcfd_pkg::FUNC_DATA, body[i]);
    endtask

    // One random sequence: mostly good frames, the rest broken ones and noise
    task automatic random_sequence();
        int          choice;
        int          body_len;
        logic [31:0] len;
        if ($urandom_range(24) == 0)
            send_restart();
        choice = $urandom_range(99);
        len    = pick_length();
        if (choice < 70)
        begin
            send_packet(len, len, 1'b0);
            if (len > cur_limit)
                send_restart();
        end
        else if (choice < 80)
        begin
            // checksum mismatch, then bytes while failed
            send_packet(len, len, 1'b1);
            repeat ($urandom_range(3))
                send_item(lcfd_pkg::FUNC_DATA, 8'($urandom_range(255)));
            send_restart();
        end
        else if (choice < 86 && cur_limit != 32'hFFFF_FFFF)
        begin
            // length just over the limit, or the largest one
            if (cur_limit > 32'hFFFF_FF00 || $urandom_range(3) == 0)
                len = 32'hFFFF_FFFF;
            else
                len = cur_limit + 32'd1 + $urandom_range(63);
            send_packet(len, $urandom_range(3), 1'b0);
            send_restart();
        end
        else if (choice < 93)
        begin
            // frame cut short by a restart; length never zero here
            if ($urandom_range(1) == 1)
                len = 32'($urandom_range(32'hFFFF_FFFF, 1));
            else
                len = len + 32'd1;
            body_len = (len > 6) ? $urandom_range(6) : $urandom_range(len - 1);
            send_packet(len, body_len, 1'b0);
            send_restart();
        end
        else
        begin
            // raw noise, often stopping mid-header
            repeat ($urandom_range(1, 12))
                send_item(lcfd_pkg::FUNC_DATA, 8'($urandom_range(255)));
            send_restart();
        end
    endtask

    // Stop sending and wait until every predicted result has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB setup and access phases, then back to idle
    task automatic apb_xfer(input logic is_write, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= 3'(4 * lcfd_pkg::REG_MAX_PAYLOAD);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: good one-byte frame, empty frame with bad CRC, byte while
        // failed, restart, largest length against the reset limit, restart
        send_idle_pct  = 25;
        recv_stall_pct = 51;
        send_header(32'd1, ~body_crc_update(32'hFFFF_FFFF, 8'hFF));
        send_item(lcfd_pkg::FUNC_DATA, 8'hFF);
        send_header(32'd0, 32'h8000_0001);
        send_item(lcfd_pkg::FUNC_DATA, 8'h00);
        send_item(lcfd_pkg::FUNC_RESTART, 8'h00);
        send_header(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(lcfd_pkg::FUNC_RESTART, 8'hFF);
        drain();

        // Random phases, one limit setting each
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            apb_xfer(1'b1, phase_limit(p));
            apb_xfer(1'b0, 32'd0);
            cur_limit = phase_limit(p);
            if (p < 2)
            begin
                send_idle_pct  = 25;
                recv_stall_pct = 51;
            end
            else if (p < 4)
            begin
                send_idle_pct  = 51;
                recv_stall_pct = 25;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // long receiver hold-off while the sender keeps going
            if (p == 0 || p == 5)
                hold_requests++;
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
                random_sequence();
        end
        drain();

        $display("summary: %0d input transactions (%0d restarts), length limit at 8 settings",
                 items_sent, restarts_sent);
        $display("summary: %0d results compared, %0d frame ends, %0d error reports",
                 checked_count, frame_end_count, error_report_count);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
